// ===== rtl/core/btr_pkg.sv =====
package btr_pkg;

	// Fixed font geometry.
	localparam int GLYPH_COUNT = 64;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_CELLS = GLYPH_COLS * GLYPH_ROWS;
	localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
	localparam int CELL_CNT_W = $clog2(GLYPH_CELLS);
	localparam int COL_W = $clog2(GLYPH_COLS);

	// Largest pen scale honored; larger register values are clamped.
	localparam int MAX_SCALE = 8;
	localparam int SCALE_LIM_INT = (MAX_SCALE > 15) ? 15 : ((MAX_SCALE < 1) ? 1 : MAX_SCALE);
	localparam logic [3:0] SCALE_LIMIT = 4'(SCALE_LIM_INT);

	localparam logic [12:0] SCREEN_LIMIT = 13'd4096;

	// Depth of the job queue between the front and the back.
	localparam int JOB_QUEUE_DEPTH = 2;

	// Character codes.
	localparam logic [7:0] CHAR_END = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_FIRST = 8'h20;
	localparam logic [7:0] CHAR_LAST = 8'h5F;
	localparam logic [7:0] CHAR_SUBST = 8'h3F;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PEN_COLOR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_SCALE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

	typedef enum logic [1:0] {
		CK_END,
		CK_NEWLINE,
		CK_GLYPH
	} char_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} bk_state_t;

	// Effective configuration as seen by the front and the back.
	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [31:0] pen_color;
		logic [3:0] scale;
		logic [12:0] width_lim;
		logic [12:0] height_lim;
	} btr_cfg_t;

	// One glyph to draw: cursor position and the glyph bitmap, row 0 in the top bits.
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [GLYPH_CELLS-1:0] bits;
	} btr_job_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [3:0] width;
		logic [3:0] height;
		logic last;
	} btr_square_t;

	// Font bitmap, codes 0x20 to 0x5F, rows top to bottom, bit 4 is the leftmost column.
	localparam logic [GLYPH_CELLS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h00},
		{5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h00,5'h00},
		{5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04}, {5'h18,5'h19,5'h02,5'h04,5'h09,5'h03,5'h00},
		{5'h0C,5'h12,5'h14,5'h08,5'h15,5'h12,5'h0D}, {5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
		{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}, {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
		{5'h00,5'h04,5'h15,5'h0E,5'h15,5'h04,5'h00}, {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00},
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h08}, {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h04,5'h00}, {5'h00,5'h01,5'h02,5'h04,5'h08,5'h10,5'h00},
		{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
		{5'h0E,5'h11,5'h01,5'h06,5'h08,5'h10,5'h1F}, {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
		{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
		{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E}, {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
		{5'h00,5'h04,5'h00,5'h00,5'h00,5'h04,5'h00}, {5'h00,5'h04,5'h00,5'h00,5'h00,5'h04,5'h08},
		{5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02}, {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00},
		{5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08}, {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
		{5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0E}, {5'h04,5'h0A,5'h11,5'h11,5'h1F,5'h11,5'h11},
		{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E}, {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
		{5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C}, {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
		{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10}, {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E},
		{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
		{5'h01,5'h01,5'h01,5'h01,5'h01,5'h11,5'h0E}, {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
		{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F}, {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
		{5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11}, {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10}, {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
		{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11}, {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
		{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}, {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04}, {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A},
		{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11}, {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
		{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}, {5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E},
		{5'h00,5'h10,5'h08,5'h04,5'h02,5'h01,5'h00}, {5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E},
		{5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F}
	};

endpackage

// ===== rtl/core/btr_if.sv =====
interface btr_char_if;
	logic valid;
	logic ready;
	logic restart;
	logic [7:0] char_code;

	modport source(output valid, output restart, output char_code, input ready);
	modport sink(input valid, input restart, input char_code, output ready);
endinterface

interface btr_block_if;
	logic valid;
	logic ready;
	logic [11:0] block_x;
	logic [11:0] block_y;
	logic [3:0] block_width;
	logic [3:0] block_height;
	logic [31:0] block_color;
	logic last_block;

	modport source(output valid, output block_x, output block_y, output block_width,
		output block_height, output block_color, output last_block, input ready);
	modport sink(input valid, input block_x, input block_y, input block_width,
		input block_height, input block_color, input last_block, output ready);
endinterface

interface btr_cfg_if import btr_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/btr_front.sv =====
module btr_front import btr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input btr_cfg_t cfg_regs,
	btr_char_if.sink chars,
	output logic push_valid,
	input logic push_ready,
	output btr_job_t push_job
);

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v[16] != v[15]) begin
			r = v[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic signed [15:0] cursor_x_q;
	logic signed [15:0] cursor_y_q;
	logic signed [15:0] cur_x;
	logic signed [15:0] cur_y;
	logic [7:0] code;
	logic [7:0] glyph_code;
	logic [GLYPH_IDX_W-1:0] glyph_idx;
	logic [6:0] advance_x;
	logic [6:0] advance_y;
	logic accept;
	char_kind_t kind;

	assign code = chars.char_code;
	assign cur_x = chars.restart ? cfg_regs.origin_x : cursor_x_q;
	assign cur_y = chars.restart ? cfg_regs.origin_y : cursor_y_q;
	assign advance_x = {1'b0, cfg_regs.scale, 2'b00} + {2'b00, cfg_regs.scale, 1'b0};
	assign advance_y = {cfg_regs.scale, 3'b000};

	always_comb begin
		if (code == CHAR_END) begin
			kind = CK_END;
		end else if (code == CHAR_NEWLINE) begin
			kind = CK_NEWLINE;
		end else begin
			kind = CK_GLYPH;
		end
	end

	assign glyph_code = (code < CHAR_FIRST || code > CHAR_LAST) ? CHAR_SUBST : code;
	assign glyph_idx = GLYPH_IDX_W'(glyph_code - CHAR_FIRST);

	assign chars.ready = push_ready;
	assign accept = chars.valid && push_ready;
	assign push_valid = chars.valid && (kind == CK_GLYPH);
	assign push_job.x = cur_x;
	assign push_job.y = cur_y;
	assign push_job.bits = GLYPH_ROM[glyph_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (accept) begin
			unique case (kind)
				CK_END: begin
					cursor_x_q <= cur_x;
					cursor_y_q <= cur_y;
				end
				CK_NEWLINE: begin
					cursor_x_q <= cfg_regs.origin_x;
					cursor_y_q <= sat16(17'(cur_y) + $signed({10'b0, advance_y}));
				end
				CK_GLYPH: begin
					cursor_x_q <= sat16(17'(cur_x) + $signed({10'b0, advance_x}));
					cursor_y_q <= cur_y;
				end
				default: begin
					cursor_x_q <= cursor_x_q;
					cursor_y_q <= cursor_y_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/btr_queue.sv =====
module btr_queue import btr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input btr_job_t push_job,
	output logic pop_valid,
	input logic pop_ready,
	output btr_job_t pop_job
);

	localparam int PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

	btr_job_t entries_q [JOB_QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = count_q != CNT_W'(JOB_QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_job = entries_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/btr_back.sv =====
module btr_back import btr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input btr_cfg_t cfg_regs,
	input logic pop_valid,
	output logic pop_ready,
	input btr_job_t pop_job,
	btr_block_if.source blocks
);

	bk_state_t state_q;
	bk_state_t state_d;

	logic [GLYPH_CELLS-1:0] bits_q;
	logic [CELL_CNT_W-1:0] cell_cnt_q;
	logic [COL_W-1:0] col_q;
	logic signed [17:0] row_x_q;
	logic signed [17:0] cell_x_q;
	logic signed [17:0] cell_y_q;

	btr_square_t pend_q;
	logic pend_vld_q;
	btr_square_t out_q;
	logic out_vld_q;

	logic signed [17:0] s18;
	logic signed [17:0] w18;
	logic signed [17:0] h18;
	logic signed [17:0] x1;
	logic signed [17:0] y1;
	logic signed [17:0] x0c;
	logic signed [17:0] y0c;
	logic signed [17:0] x1c;
	logic signed [17:0] y1c;
	logic signed [17:0] dx;
	logic signed [17:0] dy;
	logic vis;
	logic out_free;
	logic scan_step;
	logic last_cell;
	logic load_out;
	logic out_last;
	btr_square_t sq;

	// Clip the current cell's square against the screen.
	assign s18 = $signed({14'b0, cfg_regs.scale});
	assign w18 = $signed({5'b0, cfg_regs.width_lim});
	assign h18 = $signed({5'b0, cfg_regs.height_lim});
	assign x1 = cell_x_q + s18;
	assign y1 = cell_y_q + s18;
	assign x0c = cell_x_q[17] ? '0 : cell_x_q;
	assign y0c = cell_y_q[17] ? '0 : cell_y_q;
	assign x1c = (x1 > w18) ? w18 : x1;
	assign y1c = (y1 > h18) ? h18 : y1;
	assign dx = x1c - x0c;
	assign dy = y1c - y0c;
	assign vis = bits_q[GLYPH_CELLS-1] && (x1c > x0c) && (y1c > y0c);

	assign sq.x = x0c[11:0];
	assign sq.y = y0c[11:0];
	assign sq.width = dx[3:0];
	assign sq.height = dy[3:0];
	assign sq.last = 1'b0;

	assign out_free = !out_vld_q || blocks.ready;
	assign last_cell = cell_cnt_q == CELL_CNT_W'(GLYPH_CELLS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_step && last_cell) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!pend_vld_q || out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		scan_step = 1'b0;
		load_out = 1'b0;
		out_last = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
			end
			BK_SCAN: begin
				// A new square pushes the held one out, which needs room.
				scan_step = !(vis && pend_vld_q && !out_free);
				load_out = scan_step && vis && pend_vld_q;
			end
			BK_FLUSH: begin
				load_out = pend_vld_q && out_free;
				out_last = 1'b1;
			end
			default: begin
				pop_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (blocks.ready) begin
				out_vld_q <= 1'b0;
			end
			if (scan_step && vis) begin
				pend_vld_q <= 1'b1;
			end else if (state_q == BK_FLUSH && out_free) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			bits_q <= pop_job.bits;
			cell_cnt_q <= '0;
			col_q <= '0;
			row_x_q <= 18'(pop_job.x);
			cell_x_q <= 18'(pop_job.x);
			cell_y_q <= 18'(pop_job.y);
		end else if (scan_step) begin
			bits_q <= {bits_q[GLYPH_CELLS-2:0], 1'b0};
			cell_cnt_q <= cell_cnt_q + 1'b1;
			if (col_q == COL_W'(GLYPH_COLS - 1)) begin
				col_q <= '0;
				cell_x_q <= row_x_q;
				cell_y_q <= cell_y_q + s18;
			end else begin
				col_q <= col_q + 1'b1;
				cell_x_q <= cell_x_q + s18;
			end
		end
		if (scan_step && vis) begin
			pend_q <= sq;
		end
		if (load_out) begin
			out_q.x <= pend_q.x;
			out_q.y <= pend_q.y;
			out_q.width <= pend_q.width;
			out_q.height <= pend_q.height;
			out_q.last <= out_last;
		end
	end

	assign blocks.valid = out_vld_q;
	assign blocks.block_x = out_q.x;
	assign blocks.block_y = out_q.y;
	assign blocks.block_width = out_q.width;
	assign blocks.block_height = out_q.height;
	assign blocks.block_color = cfg_regs.pen_color;
	assign blocks.last_block = out_q.last;

	// The held square never overwrites a result that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n) load_out |-> out_free)
		else $error("output register overwritten while still valid");

	// A character's held square is always gone before the next job starts.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == BK_IDLE) |-> !pend_vld_q)
		else $error("square left over from the previous character");

	// Flushing the held square marks it as the character's last one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_FLUSH && pend_vld_q && out_free) |=> (out_vld_q && out_q.last))
		else $error("final square not marked last");

	// The scan never runs past the glyph.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (cell_cnt_q < CELL_CNT_W'(GLYPH_CELLS)))
		else $error("cell counter out of range");

endmodule

// ===== rtl/core/bitmap_text_rasterizer.sv =====
// Bitmap text rasterizer: takes one character per item on the chars channel and returns,
// on the blocks channel, one filled square per set pixel of the character's 5x7 glyph,
// scaled by glyph_scale, clipped to the screen, in pen_color, row by row from the top and
// left to right, with last_block set on the final square of each character. A character
// whose squares all fall off screen (or a blank glyph) returns nothing but still moves
// the cursor. Code 0x00 ends a string and does nothing, 0x0A is a newline, and any other
// code outside 0x20..0x5F is drawn as a question mark. Setting restart on an item reloads
// the cursor from origin_x and origin_y before that item is handled. The front part
// classifies each character and updates the cursor in the cycle it is accepted; printable
// characters are queued as jobs for the back part, which walks the 35 glyph cells one per
// clock unless the blocks channel holds it up. For each printable character the back part
// takes the job, walks its 35 cells, finishes its last square and then returns to idle to
// take the next job. Newlines and end markers cause no result. The job queue holds two
// characters, so the chars channel keeps accepting while the back part is busy, until
// the queue is full. Configuration registers are written through the cfg channel, which is
// always ready; they should only be changed while the block is idle.
module bitmap_text_rasterizer import btr_pkg::*; (
	input logic clk,
	input logic arst_n,
	btr_cfg_if.sink cfg,
	btr_char_if.sink chars,
	btr_block_if.source blocks
);

	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;
	logic [31:0] pen_color_q;
	logic [3:0] glyph_scale_q;
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;

	btr_cfg_t cfg_regs;
	btr_job_t push_job;
	btr_job_t pop_job;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	// Register writes are taken in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			pen_color_q <= 32'hFFFF_FFFF;
			glyph_scale_q <= 4'd2;
			screen_width_q <= 13'd1280;
			screen_height_q <= 13'd720;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ORIGIN_X: origin_x_q <= cfg.data[15:0];
				REG_ORIGIN_Y: origin_y_q <= cfg.data[15:0];
				REG_PEN_COLOR: pen_color_q <= cfg.data[31:0];
				REG_GLYPH_SCALE: glyph_scale_q <= cfg.data[3:0];
				REG_SCREEN_WIDTH: screen_width_q <= cfg.data[12:0];
				REG_SCREEN_HEIGHT: screen_height_q <= cfg.data[12:0];
				default: begin
				end
			endcase
		end
	end

	// A scale of zero acts as one, and scales above the limit are clamped. Screen sizes
	// above 4096 act as 4096.
	always_comb begin
		cfg_regs.origin_x = origin_x_q;
		cfg_regs.origin_y = origin_y_q;
		cfg_regs.pen_color = pen_color_q;
		if (glyph_scale_q == 4'd0) begin
			cfg_regs.scale = 4'd1;
		end else if (glyph_scale_q > SCALE_LIMIT) begin
			cfg_regs.scale = SCALE_LIMIT;
		end else begin
			cfg_regs.scale = glyph_scale_q;
		end
		cfg_regs.width_lim = (screen_width_q > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width_q;
		cfg_regs.height_lim = (screen_height_q > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height_q;
	end

	btr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_regs),
		.chars(chars),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job)
	);

	btr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job)
	);

	btr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_regs),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job),
		.blocks(blocks)
	);

endmodule
